// File: src/cau_pkg.sv
// shared types and constants for the complex arithmetic unit
package cau_pkg;

  localparam int DW     = 16;
  localparam int Q_W    = DW;
  localparam int SUM_W  = DW + 1;
  localparam int PROD_W = 2 * DW;
  localparam int DEN_W  = 2 * DW;
  localparam int REM_W  = 2 * DW + 1;
  localparam int MAG_W  = 2 * DW + 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  operation;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 saturated;
    logic                 div_zero;
  } out_item_t;

  // one result part on its way through the divider
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   xlo;
    logic [Q_W-1:0]   q;
  } part_t;

  typedef struct packed {
    op_t              op;
    logic             dz;
    logic [DEN_W-1:0] den;
    part_t            re;
    part_t            im;
  } pipe_t;

endpackage

// File: src/cau_front.sv
// product, combine, magnitude and divider setup stages
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     out_valid,
  output pipe_t    out_pipe
);

  localparam int CMP_W = MAG_W + FRAC_BITS;

  // stage 1
  logic                     v1_r;
  op_t                      op1_r;
  logic                     dz1_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, sq_r_r, sq_i_r;
  logic signed [SUM_W-1:0]  s_re_r, s_im_r;

  // stage 2
  logic                    v2_r;
  op_t                     op2_r;
  logic                    dz2_r;
  logic signed [MAG_W-1:0] val_re_r, val_im_r;
  logic [DEN_W-1:0]        den2_r;
  logic signed [MAG_W-1:0] val_re_nxt, val_im_nxt;

  // stage 3
  logic             v3_r;
  op_t              op3_r;
  logic             dz3_r;
  logic [DEN_W-1:0] den3_r;
  logic             neg_re_r, neg_im_r;
  logic [MAG_W-1:0] mag_re_r, mag_im_r;

  // stage 4
  logic  v4_r;
  pipe_t pipe4_r;

  function automatic part_t prep(logic neg, logic [MAG_W-1:0] mag, op_t op,
                                 logic [DEN_W-1:0] den);
    logic [CMP_W-1:0] x;
    logic [CMP_W-1:0] hi;
    part_t            p;
    x     = CMP_W'(mag) << FRAC_BITS;
    hi    = x >> Q_W;
    p.neg = neg;
    p.mag = (op == OP_MUL) ? (mag >> FRAC_BITS) : mag;
    p.ovf = (hi >= CMP_W'(den));
    p.rem = hi[REM_W-1:0];
    p.xlo = x[Q_W-1:0];
    p.q   = '0;
    return p;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    op1_r  <= in_item.operation;
    dz1_r  <= (in_item.operation == OP_DIV) && (in_item.b_re == '0) && (in_item.b_im == '0);
    p_rr_r <= PROD_W'(in_item.a_re) * PROD_W'(in_item.b_re);
    p_ii_r <= PROD_W'(in_item.a_im) * PROD_W'(in_item.b_im);
    p_ir_r <= PROD_W'(in_item.a_im) * PROD_W'(in_item.b_re);
    p_ri_r <= PROD_W'(in_item.a_re) * PROD_W'(in_item.b_im);
    sq_r_r <= PROD_W'(in_item.b_re) * PROD_W'(in_item.b_re);
    sq_i_r <= PROD_W'(in_item.b_im) * PROD_W'(in_item.b_im);
    if (in_item.operation == OP_SUB) begin
      s_re_r <= SUM_W'(in_item.a_re) - SUM_W'(in_item.b_re);
      s_im_r <= SUM_W'(in_item.a_im) - SUM_W'(in_item.b_im);
    end else begin
      s_re_r <= SUM_W'(in_item.a_re) + SUM_W'(in_item.b_re);
      s_im_r <= SUM_W'(in_item.a_im) + SUM_W'(in_item.b_im);
    end
  end

  always_comb begin
    unique case (op1_r)
      OP_ADD, OP_SUB: begin
        val_re_nxt = MAG_W'(s_re_r);
        val_im_nxt = MAG_W'(s_im_r);
      end
      OP_MUL: begin
        val_re_nxt = MAG_W'(p_rr_r) - MAG_W'(p_ii_r);
        val_im_nxt = MAG_W'(p_ir_r) + MAG_W'(p_ri_r);
      end
      OP_DIV: begin
        val_re_nxt = MAG_W'(p_rr_r) + MAG_W'(p_ii_r);
        val_im_nxt = MAG_W'(p_ir_r) - MAG_W'(p_ri_r);
      end
      default: begin
        val_re_nxt = '0;
        val_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    op2_r    <= op1_r;
    dz2_r    <= dz1_r;
    val_re_r <= val_re_nxt;
    val_im_r <= val_im_nxt;
    den2_r   <= DEN_W'(unsigned'(sq_r_r)) + DEN_W'(unsigned'(sq_i_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    op3_r    <= op2_r;
    dz3_r    <= dz2_r;
    den3_r   <= den2_r;
    neg_re_r <= val_re_r[MAG_W-1];
    neg_im_r <= val_im_r[MAG_W-1];
    mag_re_r <= val_re_r[MAG_W-1] ? MAG_W'(-val_re_r) : MAG_W'(val_re_r);
    mag_im_r <= val_im_r[MAG_W-1] ? MAG_W'(-val_im_r) : MAG_W'(val_im_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    pipe4_r.op  <= op3_r;
    pipe4_r.dz  <= dz3_r;
    pipe4_r.den <= den3_r;
    pipe4_r.re  <= prep(neg_re_r, mag_re_r, op3_r, den3_r);
    pipe4_r.im  <= prep(neg_im_r, mag_im_r, op3_r, den3_r);
  end

  assign out_valid = v4_r;
  assign out_pipe  = pipe4_r;

endmodule

// File: src/cau_div_step.sv
// one restoring divider stage, one quotient bit per part
module cau_div_step import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  pipe_t in_pipe,
  output logic  out_valid,
  output pipe_t out_pipe
);

  logic  valid_r;
  pipe_t pipe_r;

  function automatic part_t step(part_t p, logic [DEN_W-1:0] den);
    logic [REM_W:0] t;
    part_t          r;
    r     = p;
    t     = {p.rem, p.xlo[Q_W-1]};
    r.xlo = {p.xlo[Q_W-2:0], 1'b0};
    if (t >= (REM_W+1)'(den)) begin
      r.rem = REM_W'(t - (REM_W+1)'(den));
      r.q   = {p.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = t[REM_W-1:0];
      r.q   = {p.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    pipe_r.op  <= in_pipe.op;
    pipe_r.dz  <= in_pipe.dz;
    pipe_r.den <= in_pipe.den;
    pipe_r.re  <= step(in_pipe.re, in_pipe.den);
    pipe_r.im  <= step(in_pipe.im, in_pipe.den);
  end

  assign out_valid = valid_r;
  assign out_pipe  = pipe_r;

endmodule

// File: src/cau_back.sv
// result select and saturation stage
module cau_back import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  pipe_t     in_pipe,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (DW - 1);

  logic      valid_r;
  out_item_t item_r;
  out_item_t item_nxt;
  logic      clip_re, clip_im;

  function automatic logic [DW:0] sat(part_t p, op_t op);
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] nm;
    logic [DW:0]      r;
    if (op == OP_DIV) begin
      m = p.ovf ? '1 : MAG_W'(p.q);
    end else begin
      m = p.mag;
    end
    nm = ~m + MAG_W'(1);
    if (p.neg) begin
      if (m > HALF) begin
        r = {1'b1, HALF[DW-1:0]};
      end else begin
        r = {1'b0, nm[DW-1:0]};
      end
    end else begin
      if (m > HALF - MAG_W'(1)) begin
        r = {1'b1, ~HALF[DW-1:0]};
      end else begin
        r = {1'b0, m[DW-1:0]};
      end
    end
    return r;
  endfunction

  always_comb begin
    {clip_re, item_nxt.res_re} = sat(in_pipe.re, in_pipe.op);
    {clip_im, item_nxt.res_im} = sat(in_pipe.im, in_pipe.op);
    item_nxt.saturated = clip_re | clip_im;
    item_nxt.div_zero  = in_pipe.dz;
    if (in_pipe.dz) begin
      item_nxt.res_re    = '0;
      item_nxt.res_im    = '0;
      item_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// File: src/complex_arith_unit_core.sv
// top level of the pipelined complex arithmetic unit
//
// channel  ports                 handshake
// input    in_item               taken when start is high and busy is low
// result   out_item, out_valid   out_valid high for one cycle per item
//
// one item enters every cycle; each result passes through 4 front stages,
// one divider stage per quotient bit and 1 saturation stage.
// busy stays low: the pipeline never stalls and the receiver takes every result.
// synchronous reset clears the valid bits of every stage; data is not reset.
module complex_arith_unit_core import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic        front_valid;
  pipe_t       front_pipe;
  logic [Q_W:0] div_valid;
  pipe_t       div_pipe [Q_W+1];

  assign busy = 1'b0;

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_item),
    .out_valid(front_valid),
    .out_pipe (front_pipe)
  );

  assign div_valid[0] = front_valid;
  assign div_pipe[0]  = front_pipe;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    cau_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (div_valid[i]),
      .in_pipe  (div_pipe[i]),
      .out_valid(div_valid[i+1]),
      .out_pipe (div_pipe[i+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (div_valid[Q_W]),
    .in_pipe  (div_pipe[Q_W]),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.div_zero |->
      out_item.res_re == '0 && out_item.res_im == '0 && !out_item.saturated)
    else $error("divide by zero result not cleared");

  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      out_item.res_re == S_MAX || out_item.res_re == S_MIN ||
      out_item.res_im == S_MAX || out_item.res_im == S_MIN)
    else $error("saturated item without a clipped part");

  a_dz_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid[Q_W] && div_pipe[Q_W].dz |-> div_pipe[Q_W].op == OP_DIV)
    else $error("divide by zero flag on a non-divide item");

  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid[Q_W] |=> out_valid)
    else $error("item lost between divider and output stage");

endmodule
